@@ rtl/core/ple_pkg.sv @@
// Package for the positional list engine: command, status and cell operation codes.
// Default capacity. No dependencies.
`default_nettype none
package ple_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_RETRIEVE = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Operation applied by every cell in the chain in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } cell_op_t;

  // Control that the top level broadcasts along the chain
  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/ple_in_if.sv @@
// Command channel interface: valid/ready handshake with command, position and value.
// Depends on ple_pkg.
`default_nettype none
interface ple_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ple_pkg::CMD_W-1:0]              command;
  logic signed [ple_pkg::POS_W-1:0]       position;
  logic signed [ple_pkg::DATA_W-1:0]      value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ple_out_if.sv @@
// Result channel interface: valid/ready handshake with status, read value and count.
// Depends on ple_pkg.
`default_nettype none
interface ple_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [ple_pkg::STATUS_W-1:0]           status;
  logic signed [ple_pkg::DATA_W-1:0]      read_value;
  logic [ple_pkg::COUNT_W-1:0]            count;

  modport source (output valid, output status, output read_value, output count, input ready);
  modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ple_cell.sv @@
// One list cell: holds the item at a fixed position and takes from its neighbours.
// Depends on ple_pkg.
`default_nettype none
module ple_cell #(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  wire logic                               clk,
  input  wire ple_pkg::cell_ctrl_t                ctrl,
  input  wire logic [IW-1:0]                      at,
  input  wire logic [ple_pkg::DATA_W-1:0]         value,
  input  wire logic [ple_pkg::DATA_W-1:0]         left_i,
  input  wire logic [ple_pkg::DATA_W-1:0]         right_i,
  output logic [ple_pkg::DATA_W-1:0]              data_o,
  output logic [ple_pkg::DATA_W-1:0]              rd_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [ple_pkg::DATA_W-1:0] data_r;
  logic [ple_pkg::DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      ple_pkg::OP_INSERT: begin
        if (MY_IDX == at) begin
          data_nxt = value;
        end else if (MY_IDX > at) begin
          data_nxt = left_i;
        end
      end
      ple_pkg::OP_REMOVE: begin
        if (MY_IDX >= at) begin
          data_nxt = right_i;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (MY_IDX == at) ? data_r : '0;

endmodule
`default_nettype wire

@@ rtl/core/positional_list_engine.sv @@
// Positional list engine: ordered list of signed 32-bit items held in a chain of cells.
// Result: registered at the command transaction and presented in the cycle after it.
// Throughput: one command per cycle while the result channel is ready; every cell shifts or loads in parallel.
// Reset: rst_n (synchronous) empties the list and drops any pending result.
// Cell contents are not reset; only positions below the fill count are ever read.
// Depends on ple_pkg, ple_in_if, ple_out_if and ple_cell.
`default_nettype none
module positional_list_engine #(
  parameter int unsigned CAPACITY = ple_pkg::CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ple_in_if.sink     in_ch,
  ple_out_if.source  out_ch
);

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = ((FW > ple_pkg::POS_W) ? FW : ple_pkg::POS_W) + 1;
  localparam int unsigned DW = ple_pkg::DATA_W;

  logic [FW-1:0]                  fill_r;
  logic [FW-1:0]                  fill_nxt;
  logic                           out_valid_r;
  logic [ple_pkg::STATUS_W-1:0]   status_r;
  logic [DW-1:0]                  rd_r;
  logic [ple_pkg::COUNT_W-1:0]    count_r;

  logic                           acc;
  logic signed [CW-1:0]           pos_s;
  logic signed [CW-1:0]           fill_s;
  logic signed [CW-1:0]           ins_s;
  logic                           in_range;
  logic                           full;
  logic [IW-1:0]                  at;
  ple_pkg::cell_ctrl_t            ctrl;
  ple_pkg::status_t               status;
  logic [DW-1:0]                  rd_val;
  logic [DW-1:0]                  rd_sel;
  logic [31:0]                    fill_ext;

  logic [DW-1:0] cell_data [CAPACITY];
  logic [DW-1:0] cell_rd   [CAPACITY];

  assign acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  assign pos_s    = {{(CW - ple_pkg::POS_W){in_ch.position[ple_pkg::POS_W-1]}}, in_ch.position};
  assign fill_s   = signed'(CW'(fill_r));
  assign in_range = (pos_s >= 0) && (pos_s < fill_s);
  assign full     = (fill_r == FW'(CAPACITY));

  always_comb begin
    if ((fill_r == '0) || (pos_s < 1)) begin
      ins_s = '0;
    end else if (pos_s > fill_s) begin
      ins_s = fill_s;
    end else begin
      ins_s = pos_s;
    end
  end

  always_comb begin
    ctrl.op  = ple_pkg::OP_HOLD;
    status   = ple_pkg::ST_RANGE;
    fill_nxt = fill_r;
    at       = pos_s[IW-1:0];
    rd_val   = '0;
    case (ple_pkg::cmd_t'(in_ch.command))
      ple_pkg::CMD_INSERT: begin
        at = ins_s[IW-1:0];
        if (full) begin
          status = ple_pkg::ST_FULL;
        end else begin
          status   = ple_pkg::ST_DONE;
          fill_nxt = fill_r + FW'(1);
          if (acc) begin
            ctrl.op = ple_pkg::OP_INSERT;
          end
        end
      end
      ple_pkg::CMD_REMOVE: begin
        if (in_range) begin
          status   = ple_pkg::ST_DONE;
          fill_nxt = fill_r - FW'(1);
          if (acc) begin
            ctrl.op = ple_pkg::OP_REMOVE;
          end
        end
      end
      ple_pkg::CMD_RETRIEVE: begin
        if (in_range) begin
          status = ple_pkg::ST_DONE;
          rd_val = rd_sel;
        end
      end
      default: status = ple_pkg::ST_RANGE;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left_d;
    logic [DW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = in_ch.value;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ple_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .at      (at),
      .value   (in_ch.value),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  assign fill_ext = 32'(fill_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold result payload until the next command transaction
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status;
      rd_r     <= rd_val;
      count_r  <= fill_ext[ple_pkg::COUNT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.read_value = rd_r;
  assign out_ch.count      = count_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch.command == ple_pkg::CMD_INSERT) && !full |=> fill_r == $past(fill_r) + FW'(1))
    else $error("insert did not grow the list");

  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (status == ple_pkg::ST_FULL) |-> fill_r == FW'(CAPACITY))
    else $error("full status below capacity");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ple_pkg::ST_DONE) |-> rd_r == '0)
    else $error("read value not zero on failed command");
`endif

endmodule
`default_nettype wire
